FILE: design/sfwb_pkg.sv
// ----------------------------------------------------------------------------
// sfwb_pkg
// Types, codes and helpers shared by the sensor frame window buffer.
// ----------------------------------------------------------------------------
package sfwb_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned MAX_CH  = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam logic [2:0] REQ_PUT    = 3'd0;
  localparam logic [2:0] REQ_FPUT   = 3'd1;
  localparam logic [2:0] REQ_AT     = 3'd2;
  localparam logic [2:0] REQ_RANGE  = 3'd3;
  localparam logic [2:0] REQ_LAST   = 3'd4;
  localparam logic [2:0] REQ_COLUMN = 3'd5;
  localparam logic [2:0] REQ_CLEAR  = 3'd6;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FILTERED = 3'd1;
  localparam logic [2:0] ST_INDEX    = 3'd2;
  localparam logic [2:0] ST_REVERSED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNLIMITED  = 2'd1;

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [1:0]        meas_sel;
    logic signed [15:0] match_value;
    logic signed [15:0] in_m0;
    logic signed [15:0] in_m1;
    logic signed [15:0] in_m2;
    logic signed [15:0] in_m3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [15:0] out_m0;
    logic signed [15:0] out_m1;
    logic signed [15:0] out_m2;
    logic signed [15:0] out_m3;
    logic              last_of_run;
    logic [CNT_W-1:0]  frame_count;
    logic              is_full;
    logic              is_fresh;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e                    kind;
    logic [2:0]                   status;
    logic [IDX_W-1:0]             slot;
    logic [CNT_W-1:0]             len;
    logic                         col;
    logic [1:0]                   sel;
    logic [MAX_CH-1:0][SMP_W-1:0] data;
    logic [CNT_W-1:0]             count;
    logic                         full;
    logic                         fresh;
  } cmd_t;

  function automatic logic signed [SMP_W-1:0] sext_smp(input logic [SMP_W-1:0] x,
                                                      input int unsigned bits);
    logic signed [SMP_W-1:0] t;
    t = x << (SMP_W - bits);
    return t >>> (SMP_W - bits);
  endfunction

endpackage

FILE: design/sfwb_ram.sv
// ----------------------------------------------------------------------------
// sfwb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfwb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sfwb_cmd_queue.sv
// ----------------------------------------------------------------------------
// sfwb_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sfwb_cmd_queue
  import sfwb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  cmd_t               ent_q [QDEPTH];
  logic [PW-1:0]      wr_q, wr_d;
  logic [PW-1:0]      rd_q, rd_d;
  logic [PW:0]        cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = ent_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: design/sfwb_front.sv
// ----------------------------------------------------------------------------
// sfwb_front
// Accepts requests, tracks window count, pointer and fresh flag, and turns
// each request except REQ_UNUSED into a result, store-write or read-run command.
// ----------------------------------------------------------------------------
module sfwb_front
  import sfwb_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output cmd_t                 push_cmd_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] max_len_q;
  logic             unl_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             fresh_q, fresh_d;

  logic                         acc;
  logic [CNT_W-1:0]             eff_max, cnt7, ia7, ib7;
  logic                         sel_ok, match_ok, do_put;
  logic [MAX_CH-1:0][SMP_W-1:0] smp;
  logic signed [SMP_W-1:0]      sel_smp;
  cmd_t                         cmd;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= (AW+1)'(DEPTH)) ? s - (AW+1)'(DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign acc          = in_valid_i && in_ready_o;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (in_item_i.req_type != REQ_UNUSED);
  assign push_cmd_o   = cmd;

  assign smp     = {in_item_i.in_m3, in_item_i.in_m2, in_item_i.in_m1, in_item_i.in_m0};
  assign eff_max = (max_len_q == '0) ? CNT_W'(1) :
                   (max_len_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_len_q;
  assign cnt7    = CNT_W'(cnt_q);
  assign ia7     = CNT_W'(in_item_i.index_a);
  assign ib7     = CNT_W'(in_item_i.index_b);
  assign sel_ok  = ({1'b0, in_item_i.meas_sel} < 3'(CHANNELS));
  assign sel_smp = sext_smp(smp[in_item_i.meas_sel] & SMP_W'((1 << SAMPLE_BITS) - 1),
                            SAMPLE_BITS);
  assign match_ok = (sel_smp == in_item_i.match_value);

  always_comb begin
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    fresh_d = fresh_q;
    cmd        = '0;
    cmd.kind   = CMD_RESULT;
    cmd.status = ST_OK;
    cmd.len    = CNT_W'(1);
    cmd.sel    = in_item_i.meas_sel;
    cmd.data   = smp;
    do_put     = 1'b0;

    unique case (in_item_i.req_type)
      REQ_PUT: begin
        do_put = 1'b1;
      end
      REQ_FPUT: begin
        if (!sel_ok) begin
          cmd.status = ST_INDEX;
        end else if (!match_ok) begin
          cmd.status = ST_FILTERED;
        end else begin
          do_put = 1'b1;
        end
      end
      REQ_AT: begin
        if (cnt_q == '0) begin
          cmd.status = ST_EMPTY;
        end else if (ia7 >= cnt7) begin
          cmd.status = ST_INDEX;
        end else begin
          cmd.kind = CMD_READ;
          cmd.slot = IDX_W'(wrap((AW+1)'(ptr_q) + (AW+1)'(in_item_i.index_a)));
        end
      end
      REQ_RANGE: begin
        fresh_d = 1'b0;
        if (cnt_q == '0) begin
          cmd.status = ST_EMPTY;
        end else if (ia7 >= cnt7 || ib7 >= cnt7) begin
          cmd.status = ST_INDEX;
        end else if (ia7 > ib7) begin
          cmd.status = ST_REVERSED;
        end else begin
          cmd.kind = CMD_READ;
          cmd.slot = IDX_W'(wrap((AW+1)'(ptr_q) + (AW+1)'(in_item_i.index_a)));
          cmd.len  = ib7 - ia7 + CNT_W'(1);
        end
      end
      REQ_LAST: begin
        fresh_d = 1'b0;
        if (cnt_q == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind = CMD_READ;
          cmd.slot = IDX_W'(wrap((AW+1)'(ptr_q) + (AW+1)'(cnt_q) - (AW+1)'(1)));
        end
      end
      REQ_COLUMN: begin
        if (!sel_ok) begin
          cmd.status = ST_INDEX;
        end else if (cnt_q == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind = CMD_READ;
          cmd.col  = 1'b1;
          cmd.slot = IDX_W'(ptr_q);
          cmd.len  = cnt7;
        end
      end
      REQ_CLEAR: begin
        cnt_d = '0;
        ptr_d = '0;
      end
      default: begin
      end
    endcase

    if (do_put) begin
      if (cnt_q == CW'(DEPTH)) begin
        if (unl_q) begin
          cmd.status = ST_OVERFLOW;
        end else begin
          cmd.kind = CMD_WRITE;
          cmd.slot = IDX_W'(ptr_q);
          ptr_d    = wrap((AW+1)'(ptr_q) + (AW+1)'(1));
          fresh_d  = 1'b1;
        end
      end else begin
        cmd.kind = CMD_WRITE;
        cmd.slot = IDX_W'(wrap((AW+1)'(ptr_q) + (AW+1)'(cnt_q)));
        fresh_d  = 1'b1;
        if (!unl_q && (cnt7 + CNT_W'(1) > eff_max)) begin
          ptr_d = wrap((AW+1)'(ptr_q) + (AW+1)'(1));
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
    end

    cmd.count = CNT_W'(cnt_d);
    cmd.full  = !unl_q && (CNT_W'(cnt_d) == eff_max);
    cmd.fresh = fresh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      fresh_q   <= 1'b0;
      max_len_q <= CNT_W'(64);
      unl_q     <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q   <= cnt_d;
        ptr_q   <= ptr_d;
        fresh_q <= fresh_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_LENGTH: max_len_q <= cfg_wdata_i;
          REG_UNLIMITED:  unl_q     <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: design/sfwb_back.sv
// ----------------------------------------------------------------------------
// sfwb_back
// Executes queued commands in order: writes frames, walks read runs through
// the frame memory and drives the output register.
// ----------------------------------------------------------------------------
module sfwb_back
  import sfwb_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = CHANNELS * SAMPLE_BITS;

  typedef struct packed {
    logic             last;
    logic             col;
    logic [1:0]       sel;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             fresh;
  } rd_meta_t;

  logic [CNT_W-1:0] pos_q, pos_d;
  logic             rd_pend_q, rd_pend_d;
  rd_meta_t         meta_q, meta_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic                         out_free, mv, imm, issue, run_end;
  logic [AW-1:0]                raddr, waddr;
  logic [AW:0]                  rsum;
  logic [FW-1:0]                wdata, rdata;
  logic [MAX_CH-1:0][SMP_W-1:0] rsmp;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_used
      assign wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = head_cmd_i.data[c][SAMPLE_BITS-1:0];
      assign rsmp[c] = sext_smp(SMP_W'(rdata[c*SAMPLE_BITS +: SAMPLE_BITS]), SAMPLE_BITS);
    end else begin : g_unused
      assign rsmp[c] = '0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign mv       = rd_pend_q && out_free;
  assign imm      = head_valid_i && (head_cmd_i.kind != CMD_READ) && !rd_pend_q && out_free;
  assign issue    = head_valid_i && (head_cmd_i.kind == CMD_READ) && (!rd_pend_q || mv);
  assign run_end  = (pos_q == head_cmd_i.len - CNT_W'(1));
  assign pop_o    = imm || (issue && run_end);
  assign rsum     = (AW+1)'(head_cmd_i.slot[AW-1:0]) + (AW+1)'(pos_q);
  assign raddr    = (rsum >= (AW+1)'(DEPTH)) ? AW'(rsum - (AW+1)'(DEPTH)) : rsum[AW-1:0];
  assign waddr    = head_cmd_i.slot[AW-1:0];

  sfwb_ram #(
    .WIDTH(FW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (imm && (head_cmd_i.kind == CMD_WRITE)),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    pos_d       = pos_q;
    rd_pend_d   = rd_pend_q;
    meta_d      = meta_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (mv) begin
      out_d             = '0;
      out_d.status      = ST_OK;
      out_d.last_of_run = meta_q.last;
      out_d.frame_count = meta_q.count;
      out_d.is_full     = meta_q.full;
      out_d.is_fresh    = meta_q.fresh;
      if (meta_q.col) begin
        out_d.out_m0 = rsmp[meta_q.sel];
      end else begin
        out_d.out_m0 = rsmp[0];
        out_d.out_m1 = rsmp[1];
        out_d.out_m2 = rsmp[2];
        out_d.out_m3 = rsmp[3];
      end
      out_valid_d = 1'b1;
      rd_pend_d   = 1'b0;
    end

    if (imm) begin
      out_d             = '0;
      out_d.status      = head_cmd_i.status;
      out_d.last_of_run = 1'b1;
      out_d.frame_count = head_cmd_i.count;
      out_d.is_full     = head_cmd_i.full;
      out_d.is_fresh    = head_cmd_i.fresh;
      out_valid_d       = 1'b1;
    end

    if (issue) begin
      rd_pend_d    = 1'b1;
      meta_d.last  = run_end;
      meta_d.col   = head_cmd_i.col;
      meta_d.sel   = head_cmd_i.sel;
      meta_d.count = head_cmd_i.count;
      meta_d.full  = head_cmd_i.full;
      meta_d.fresh = head_cmd_i.fresh;
      pos_d        = run_end ? '0 : pos_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/sensor_frame_window_buffer_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_window_buffer_core
// Sliding window of sensor frames with drop-oldest or reject-when-full puts.
// Puts, clear and errors: one item per cycle while out_ready_i is high, via
// queue and output register. Reads: queue, memory read and output register,
// then one frame per cycle for range and column runs if out_ready_i is high.
// Reset clears count, pointer, fresh flag, queue and output; the frame memory
// keeps its contents. Registers reset to max_length 64, unlimited_mode 0.
// ----------------------------------------------------------------------------
module sensor_frame_window_buffer_core
  import sfwb_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  logic push_valid, push_ready, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  sfwb_front #(
    .DEPTH      (DEPTH),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  sfwb_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (head_valid),
    .pop_i       (pop),
    .pop_cmd_o   (head_cmd)
  );

  sfwb_back #(
    .DEPTH      (DEPTH),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_cmd_i  (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: design/sfwb_checker.sv
// ----------------------------------------------------------------------------
// sfwb_checker
// Port-level checks of the sensor frame window buffer, bound to the top level.
// ----------------------------------------------------------------------------
module sfwb_checker
  import sfwb_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.last_of_run)
    else $error("error result not last of run");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.out_m0 == '0 && out_item_o.out_m1 == '0 &&
      out_item_o.out_m2 == '0 && out_item_o.out_m3 == '0)
    else $error("error result carries data");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.frame_count <= CNT_W'(DEPTH))
    else $error("frame count above depth");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_full |-> out_item_o.frame_count != '0)
    else $error("full flag with empty window");

endmodule

bind sensor_frame_window_buffer_core sfwb_checker #(
  .DEPTH(DEPTH)
) u_sfwb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

FILE: dv/sensor_frame_window_buffer_core_test.sv
// ----------------------------------------------------------------------------
// sensor_frame_window_buffer_core_test
// Self-checking bench for the frame window buffer. A clocked driver feeds
// requests from a backlog queue with random gaps. A predictor mirrors the
// window, pointer, count, fresh flag and registers, and queues the replies
// each accepted request should produce. A clocked monitor takes replies under
// random back-pressure and compares every field in order. Register settings
// change between phases while the block is idle: window lengths 1, 64, 5, 3,
// 0 and 127, with limited and unlimited modes.
// ----------------------------------------------------------------------------
module sensor_frame_window_buffer_core_test;
  import sfwb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_DEPTH  = 64;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  sensor_frame_window_buffer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  in_item_t    request_backlog[$];
  out_item_t   frame_replies[$];
  int unsigned gap_pct = 9;
  int unsigned hold_trigs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;

  // mirror of the block
  logic [63:0] win_mem[WIN_DEPTH];
  int unsigned win_head = 0;
  int unsigned win_count = 0;
  bit          win_fresh = 1'b0;
  logic [6:0]  win_max_len = 7'd64;
  bit          win_unlim = 1'b0;

  function automatic int unsigned eff_len();
    if (win_max_len == 0) return 1;
    if (win_max_len > WIN_DEPTH) return WIN_DEPTH;
    return 32'(win_max_len);
  endfunction

  function automatic logic [63:0] frame_at(input int unsigned i);
    return win_mem[(win_head + i) % WIN_DEPTH];
  endfunction

  function automatic void add_req(input in_item_t it);
    request_backlog = {request_backlog, it};
  endfunction

  function automatic void post_reply(input logic [2:0] st, input logic [63:0] fr,
                                     input bit last);
    out_item_t r;
    r.status      = st;
    r.out_m0      = fr[15:0];
    r.out_m1      = fr[31:16];
    r.out_m2      = fr[47:32];
    r.out_m3      = fr[63:48];
    r.last_of_run = last;
    r.frame_count = CNT_W'(win_count);
    r.is_full     = !win_unlim && (win_count == eff_len());
    r.is_fresh    = win_fresh;
    frame_replies = {frame_replies, r};
  endfunction

  function automatic logic [2:0] store_frame(input in_item_t it);
    logic [63:0] f;
    f = {it.in_m3, it.in_m2, it.in_m1, it.in_m0};
    if (win_count >= WIN_DEPTH) begin
      if (win_unlim) return ST_OVERFLOW;
      win_mem[win_head] = f;
      win_head = (win_head + 1) % WIN_DEPTH;
    end else begin
      win_mem[(win_head + win_count) % WIN_DEPTH] = f;
      win_count++;
      if (!win_unlim && win_count > eff_len()) begin
        win_head = (win_head + 1) % WIN_DEPTH;
        win_count--;
      end
    end
    win_fresh = 1'b1;
    return ST_OK;
  endfunction

  function automatic void step_window(input in_item_t it);
    logic [63:0] f;
    logic [2:0]  st;
    int unsigned ia, ib;
    ia = 32'(it.index_a);
    ib = 32'(it.index_b);
    case (it.req_type)
      REQ_PUT: begin
        st = store_frame(it);
        post_reply(st, '0, 1'b1);
      end
      REQ_FPUT: begin
        f = {it.in_m3, it.in_m2, it.in_m1, it.in_m0};
        if (f[it.meas_sel*16 +: 16] != it.match_value) st = ST_FILTERED;
        else st = store_frame(it);
        post_reply(st, '0, 1'b1);
      end
      REQ_AT: begin
        if (win_count == 0) post_reply(ST_EMPTY, '0, 1'b1);
        else if (ia >= win_count) post_reply(ST_INDEX, '0, 1'b1);
        else post_reply(ST_OK, frame_at(ia), 1'b1);
      end
      REQ_RANGE: begin
        win_fresh = 1'b0;
        if (win_count == 0) post_reply(ST_EMPTY, '0, 1'b1);
        else if (ia >= win_count || ib >= win_count) post_reply(ST_INDEX, '0, 1'b1);
        else if (ia > ib) post_reply(ST_REVERSED, '0, 1'b1);
        else for (int unsigned i = ia; i <= ib; i++) post_reply(ST_OK, frame_at(i), i == ib);
      end
      REQ_LAST: begin
        win_fresh = 1'b0;
        if (win_count == 0) post_reply(ST_EMPTY, '0, 1'b1);
        else post_reply(ST_OK, frame_at(win_count - 1), 1'b1);
      end
      REQ_COLUMN: begin
        if (win_count == 0) post_reply(ST_EMPTY, '0, 1'b1);
        else for (int unsigned i = 0; i < win_count; i++) begin
          f = frame_at(i);
          post_reply(ST_OK, {48'b0, f[it.meas_sel*16 +: 16]}, i + 1 == win_count);
        end
      end
      REQ_CLEAR: begin
        win_count = 0;
        win_head  = 0;
        post_reply(ST_OK, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) step_window(in_item);
      if (!in_valid || in_ready) begin
        if (request_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_item  <= request_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with a long hold on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_trigs) begin
      hold_seen <= hold_trigs;
      hold_left <= 250;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= gap_pct);
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (frame_replies.size() == 0) begin
        $error("unexpected item: status %0d count %0d", out_item.status, out_item.frame_count);
        mismatch_count++;
      end else begin
        want = frame_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("out_m0", 32'(want.out_m0), 32'(out_item.out_m0));
        check_field("out_m1", 32'(want.out_m1), 32'(out_item.out_m1));
        check_field("out_m2", 32'(want.out_m2), 32'(out_item.out_m2));
        check_field("out_m3", 32'(want.out_m3), 32'(out_item.out_m3));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_item.last_of_run));
        check_field("frame_count", 32'(want.frame_count), 32'(out_item.frame_count));
        check_field("is_full", 32'(want.is_full), 32'(out_item.is_full));
        check_field("is_fresh", 32'(want.is_fresh), 32'(out_item.is_fresh));
      end
    end
  end

  function automatic in_item_t mk(input logic [2:0] rq, input logic [5:0] a, input logic [5:0] b,
                                  input logic [1:0] sel, input logic [15:0] mv,
                                  input logic [15:0] m0, input logic [15:0] m1,
                                  input logic [15:0] m2, input logic [15:0] m3);
    in_item_t it;
    it.req_type    = rq;
    it.index_a     = a;
    it.index_b     = b;
    it.meas_sel    = sel;
    it.match_value = mv;
    it.in_m0       = m0;
    it.in_m1       = m1;
    it.in_m2       = m2;
    it.in_m3       = m3;
    return it;
  endfunction

  function automatic in_item_t rand_item(input int unsigned put_pct, input bit with_clear);
    in_item_t    it;
    logic [63:0] f;
    int unsigned pick;
    it.index_a     = IDX_W'($urandom_range(0, 63));
    it.index_b     = IDX_W'($urandom_range(0, 63));
    it.meas_sel    = 2'($urandom_range(0, 3));
    it.match_value = 16'($urandom_range(0, 65535));
    it.in_m0       = 16'($urandom_range(0, 65535));
    it.in_m1       = 16'($urandom_range(0, 65535));
    it.in_m2       = 16'($urandom_range(0, 65535));
    it.in_m3       = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) != 0) begin
      it.index_a = IDX_W'($urandom_range(0, 7));
      it.index_b = IDX_W'(32'(it.index_a) + $urandom_range(0, 7));
    end
    if ($urandom_range(0, 99) < put_pct) begin
      it.req_type = REQ_PUT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 4) it.req_type = REQ_FPUT;
      else if (pick < 8) it.req_type = REQ_AT;
      else if (pick < 11) it.req_type = REQ_RANGE;
      else if (pick < 14) it.req_type = REQ_LAST;
      else if (pick < 16) it.req_type = REQ_COLUMN;
      else if (pick < 18) it.req_type = with_clear ? REQ_CLEAR : REQ_AT;
      else if (pick < 19) it.req_type = REQ_UNUSED;
      else it.req_type = REQ_PUT;
    end
    if (it.req_type == REQ_FPUT && $urandom_range(0, 1) == 1) begin
      f = {it.in_m3, it.in_m2, it.in_m1, it.in_m0};
      it.match_value = f[it.meas_sel*16 +: 16];
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_LENGTH) win_max_len = val;
    else if (idx == REG_UNLIMITED) win_unlim = val[0];
  endtask

  task automatic send_random(input int unsigned n, input int unsigned put_pct,
                             input bit with_clear);
    @(negedge clk_i);
    repeat (n) add_req(rand_item(put_pct, with_clear));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || in_valid || frame_replies.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    add_req(mk(REQ_AT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_LAST, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_COLUMN, 0, 0, 1, 0, 0, 0, 0, 0));
    add_req(mk(REQ_PUT, 63, 63, 3, 16'h8000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000));
    add_req(mk(REQ_PUT, 0, 0, 0, 16'h7fff,
               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    add_req(mk(REQ_PUT, 21, 42, 2, 16'hffff,
               16'h0000, 16'hffff, 16'h0001, 16'h5a5a));
    add_req(mk(REQ_FPUT, 0, 0, 3, 16'h1234,
               16'h0101, 16'h0202, 16'h0303, 16'h1234));
    add_req(mk(REQ_FPUT, 0, 0, 0, 16'h0005,
               16'h0006, 16'h0007, 16'h0008, 16'h0009));
    add_req(mk(REQ_AT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_AT, 3, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_AT, 4, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_AT, 63, 63, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 0, 3, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 2, 2, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 3, 1, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 1, 63, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_LAST, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_COLUMN, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_COLUMN, 0, 0, 3, 0, 0, 0, 0, 0));
    add_req(mk(REQ_UNUSED, 63, 63, 3, 16'hffff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff));
    add_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_LAST, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_RANGE, 5, 2, 0, 0, 0, 0, 0, 0));
    add_req(mk(REQ_PUT, 0, 0, 0, 0,
               16'h1111, 16'h2222, 16'h3333, 16'h4444));
    wait_idle();

    write_reg(REG_MAX_LENGTH, 7'd1);
    write_reg(REG_UNLIMITED, 7'd0);
    send_random(40, 45, 1'b1);
    wait_idle();

    // unlimited: fill to overflow while the receiver holds off
    write_reg(REG_MAX_LENGTH, 7'd64);
    write_reg(REG_UNLIMITED, 7'd1);
    @(negedge clk_i);
    hold_trigs++;
    send_random(100, 85, 1'b0);
    wait_idle();

    // length lowered below the count
    write_reg(REG_UNLIMITED, 7'd0);
    write_reg(REG_MAX_LENGTH, 7'd5);
    send_random(30, 45, 1'b1);
    wait_idle();
    write_reg(REG_MAX_LENGTH, 7'd3);
    send_random(30, 45, 1'b1);
    wait_idle();

    write_reg(REG_MAX_LENGTH, 7'd0);
    send_random(25, 45, 1'b1);
    wait_idle();
    write_reg(REG_MAX_LENGTH, 7'd127);
    send_random(25, 60, 1'b0);
    wait_idle();

    // limited, full window wrapping, no gaps on either side
    write_reg(REG_MAX_LENGTH, 7'd64);
    write_reg(REG_UNLIMITED, 7'd0);
    gap_pct = 0;
    send_random(80, 85, 1'b0);
    wait_idle();
    gap_pct = 9;

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
design/sfwb_pkg.sv
design/sfwb_ram.sv
design/sfwb_cmd_queue.sv
design/sfwb_front.sv
design/sfwb_back.sv
design/sensor_frame_window_buffer_core.sv
design/sfwb_checker.sv
dv/sensor_frame_window_buffer_core_test.sv
